>>> rtl/core/kdet_pkg.sv
package kdet_pkg;

   localparam int unsigned CodeW  = 8;
   localparam int unsigned ValueW = 54;
   localparam int unsigned SlotW  = 4;
   localparam int unsigned DigitW = 4;

   localparam logic [CodeW-1:0] CodeKey1  = 8'h02;
   localparam logic [CodeW-1:0] CodeKey9  = 8'h0A;
   localparam logic [CodeW-1:0] CodeKey0  = 8'h0B;
   localparam logic [CodeW-1:0] CodeEnter = 8'h1C;

   typedef struct packed {
      logic              valid;
      logic [ValueW-1:0] value;
   } commit_type;

endpackage

>>> rtl/core/kdet_if.sv
interface kdet_req_if import kdet_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CodeW-1:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink (input valid, input scan_code, output ready);
endinterface

interface kdet_rsp_if import kdet_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ValueW-1:0] committed_value;
   logic [SlotW-1:0]  slot;

   modport source (output valid, output committed_value, output slot, input ready);
   modport sink (input valid, input committed_value, input slot, output ready);
endinterface

>>> rtl/core/kdet_accum.sv
module kdet_accum import kdet_pkg::*; #(
   parameter int unsigned DIGITS_PER_NUMBER = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [CodeW-1:0] scan_code,
   output commit_type       commit
);

   localparam int unsigned CountW = $clog2(DIGITS_PER_NUMBER + 1);

   logic [ValueW-1:0] run_ff, run_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              is_digit;
   logic              is_enter;
   logic [DigitW-1:0] digit;
   logic [ValueW-1:0] run_next;

   assign is_digit = ((scan_code >= CodeKey1) && (scan_code <= CodeKey9)) ||
                     (scan_code == CodeKey0);
   assign is_enter = (scan_code == CodeEnter);
   assign digit    = (scan_code == CodeKey0) ? '0 : DigitW'(scan_code - 8'd1);
   // times ten as two shifted adds, kept modulo the value width
   assign run_next = (run_ff << 3) + (run_ff << 1) + ValueW'(digit);

   always_comb begin
      run_in       = run_ff;
      count_in     = count_ff;
      commit.valid = 1'b0;
      commit.value = run_ff;
      if (accept && is_enter) begin
         commit.valid = 1'b1;
         run_in       = '0;
         count_in     = '0;
      end else if (accept && is_digit) begin
         if (count_ff == CountW'(DIGITS_PER_NUMBER - 1)) begin
            commit.valid = 1'b1;
            commit.value = run_next;
            run_in       = '0;
            count_in     = '0;
         end else begin
            run_in   = run_next;
            count_in = count_ff + CountW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/core/kdet_table.sv
module kdet_table import kdet_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  commit_type commit,
   output logic       ready,
   kdet_rsp_if.source rsp
);

   localparam int unsigned IdxW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned OutDepth = 3;
   localparam logic [1:0]  OutLast  = 2'(OutDepth - 1);

   logic [ValueW-1:0] number_mem [TABLE_DEPTH];

   logic [IdxW-1:0]   slot_ff, slot_in;
   logic              pend_valid_ff;
   logic [IdxW-1:0]   pend_slot_ff;
   logic [ValueW-1:0] out_value_ff [OutDepth];
   logic [SlotW-1:0]  out_slot_ff [OutDepth];
   logic [1:0]        wr_ptr_ff, wr_ptr_in;
   logic [1:0]        rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;

   assign slot_in = (slot_ff == IdxW'(TABLE_DEPTH - 1)) ? '0 : slot_ff + IdxW'(1);

   assign push = pend_valid_ff;
   assign pop  = rsp.valid && rsp.ready;

   assign wr_ptr_in = !push ? wr_ptr_ff : ((wr_ptr_ff == OutLast) ? '0 : wr_ptr_ff + 2'd1);
   assign rd_ptr_in = !pop ? rd_ptr_ff : ((rd_ptr_ff == OutLast) ? '0 : rd_ptr_ff + 2'd1);
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   // room for the queued items plus the one being read back
   assign ready = ({1'b0, count_ff} + {2'b0, pend_valid_ff}) < 3'(OutDepth);

   assign rsp.valid           = (count_ff != '0);
   assign rsp.committed_value = out_value_ff[rd_ptr_ff];
   assign rsp.slot            = out_slot_ff[rd_ptr_ff];

   // table write on commit, read back in the cycle after
   always_ff @(posedge clock) begin
      if (commit.valid) begin
         number_mem[slot_ff] <= commit.value;
      end
      if (push) begin
         out_value_ff[wr_ptr_ff] <= number_mem[pend_slot_ff];
         out_slot_ff[wr_ptr_ff]  <= SlotW'(pend_slot_ff);
      end
      pend_slot_ff <= slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         pend_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (commit.valid) begin
            slot_ff <= slot_in;
         end
         pend_valid_ff <= commit.valid;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   a_commit_pending: assert property (@(posedge clock) disable iff (reset)
      commit.valid |=> pend_valid_ff && (pend_slot_ff == $past(slot_ff)))
      else $error("committed item not pending for read back");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < 2'(OutDepth))
      else $error("output queue overflow");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      commit.valid |-> ready)
      else $error("commit without output room");

endmodule

>>> rtl/core/keypad_decimal_entry_table_unit.sv
// channel   dir  payload                         handshake
// req_ch    in   scan_code[7:0]                  valid/ready
// rsp_ch    out  committed_value[53:0], slot[3:0] valid/ready
//
// one scan code per cycle while ready is high; a commit
// writes the table in the accept cycle, reads the entry back
// the next cycle and queues it for rsp_ch.
// a three-entry output queue keeps input flowing while results wait
// synchronous reset clears the running number, digit count and write slot
module keypad_decimal_entry_table_unit import kdet_pkg::*; #(
   parameter int unsigned DIGITS_PER_NUMBER = 16,
   parameter int unsigned TABLE_DEPTH       = 16
) (
   input logic        clock,
   input logic        reset,
   kdet_req_if.sink   req_ch,
   kdet_rsp_if.source rsp_ch
);

   commit_type commit;
   logic       ready;

   assign req_ch.ready = ready;

   kdet_accum #(
      .DIGITS_PER_NUMBER (DIGITS_PER_NUMBER)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_ch.valid && ready),
      .scan_code (req_ch.scan_code),
      .commit    (commit)
   );

   kdet_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .ready  (ready),
      .rsp    (rsp_ch)
   );

endmodule
